[rtl/stg_pkg.sv]
// ----------------------------------------------------------------------------
// stg_pkg
// Shared constants, register map and types of the stepper tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

    // Default width of the tone timer.
    localparam int TIMER_BITS_DEF = 16;

    // Tone period numerator and frequency prescale (frequency / 4).
    localparam int PERIOD_SCALE = 1000000;
    localparam int FREQ_SHIFT   = 2;

    // Widths of the period divide: q below 2^14, dividend below 2^20.
    localparam int Q_BITS   = 16 - FREQ_SHIFT;
    localparam int DIV_BITS = 20;
    localparam int CNT_BITS = $clog2(DIV_BITS);

    // Item fields.
    localparam int FREQ_BITS = 16;
    localparam int DUR_BITS  = 16;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Configuration register map.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_STEP_LIMIT   = 2'd0;
    localparam logic [1:0] REG_REVERSE_EN   = 2'd1;
    localparam logic [1:0] REG_TICKS_PER_MS = 2'd2;

    localparam logic [7:0]  STEP_LIMIT_RESET   = 8'd140;
    localparam logic [15:0] TICKS_PER_MS_RESET = 16'd2000;

    typedef struct packed {
        logic [7:0]  step_limit;
        logic        reverse_enable;
        logic [15:0] ticks_per_ms;
    } t_cfg;

endpackage

`default_nettype wire

[rtl/stg_if.sv]
// ----------------------------------------------------------------------------
// stg_if
// Request channels of the stepper tone generator: note/tick in, pin state out.
// ----------------------------------------------------------------------------
`default_nettype none

interface stg_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] frequency;
    logic [15:0] duration_ms;

    modport source (output valid, command, frequency, duration_ms, input ready);
    modport sink   (input valid, command, frequency, duration_ms, output ready);
endinterface

interface stg_out_if;
    logic valid;
    logic ready;
    logic step_level;
    logic direction_level;
    logic playing;
    logic note_finished;
    logic bad_frequency;

    modport source (output valid, step_level, direction_level, playing, note_finished,
                    bad_frequency, input ready);
    modport sink   (input valid, step_level, direction_level, playing, note_finished,
                    bad_frequency, output ready);
endinterface

`default_nettype wire

[rtl/stepper_tone_generator_unit.sv]
// Path: a tick request goes through the queue into the back's output register; a note
// start first runs the bit-serial period divide (skipped when frequency / 4 is 0).
// Throughput: one tick per cycle unless stalled; no request is taken during a note start.
// Reset: synchronous, active low; clears the tone state, queue and output valid flag
// and loads the configuration registers with their reset values.
// ----------------------------------------------------------------------------
// stepper_tone_generator_unit
// Timed square-wave tone generator for a stepper head: step and direction pins.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_tone_generator_unit #(
    parameter int TIMER_BITS = stg_pkg::TIMER_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    stg_in_if.sink                               i_in,
    stg_out_if.source                            o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [stg_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [stg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [stg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    localparam int QW = 2 + TIMER_BITS + stg_pkg::DUR_BITS;

    stg_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    logic          push, pop, full, empty;
    logic [QW-1:0] push_data, pop_data;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_limit     <= stg_pkg::STEP_LIMIT_RESET;
            r_cfg.reverse_enable <= 1'b0;
            r_cfg.ticks_per_ms   <= stg_pkg::TICKS_PER_MS_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                stg_pkg::REG_STEP_LIMIT:   r_cfg.step_limit     <= pwdata[7:0];
                stg_pkg::REG_REVERSE_EN:   r_cfg.reverse_enable <= pwdata[0];
                stg_pkg::REG_TICKS_PER_MS: r_cfg.ticks_per_ms   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            stg_pkg::REG_STEP_LIMIT:   prdata = {24'd0, r_cfg.step_limit};
            stg_pkg::REG_REVERSE_EN:   prdata = {31'd0, r_cfg.reverse_enable};
            stg_pkg::REG_TICKS_PER_MS: prdata = {16'd0, r_cfg.ticks_per_ms};
            default:                   prdata = '0;
        endcase
    end

    stg_front #(
        .TIMER_BITS (TIMER_BITS),
        .QW         (QW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_command     (i_in.command),
        .i_frequency   (i_in.frequency),
        .i_duration_ms (i_in.duration_ms),
        .o_push        (push),
        .o_data        (push_data),
        .i_full        (full)
    );

    stg_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_empty (empty)
    );

    stg_back #(
        .TIMER_BITS (TIMER_BITS),
        .QW         (QW)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_data            (pop_data),
        .i_empty           (empty),
        .o_pop             (pop),
        .o_valid           (o_out.valid),
        .i_ready           (o_out.ready),
        .o_step_level      (o_out.step_level),
        .o_direction_level (o_out.direction_level),
        .o_playing         (o_out.playing),
        .o_note_finished   (o_out.note_finished),
        .o_bad_frequency   (o_out.bad_frequency)
    );

endmodule

`default_nettype wire

[rtl/stg_front.sv]
// ----------------------------------------------------------------------------
// stg_front
// Accepts requests; ticks pass straight on, note starts get their timer
// reload from a bit-serial divide of the period by frequency / 4.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_front #(
    parameter int TIMER_BITS = stg_pkg::TIMER_BITS_DEF,
    parameter int QW         = 2 + TIMER_BITS + stg_pkg::DUR_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_command,
    input  wire logic [stg_pkg::FREQ_BITS-1:0] i_frequency,
    input  wire logic [stg_pkg::DUR_BITS-1:0]  i_duration_ms,
    output logic                               o_push,
    output logic [QW-1:0]                      o_data,
    input  wire logic                          i_full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    localparam int DB = stg_pkg::DIV_BITS;
    localparam int QB = stg_pkg::Q_BITS;
    localparam int CB = stg_pkg::CNT_BITS;

    logic [1:0]                       r_state, n_state;
    logic [CB-1:0]                    r_cnt, n_cnt;
    logic [DB-1:0]                    r_quo, n_quo;
    logic [QB-1:0]                    r_rem, n_rem;
    logic [QB-1:0]                    r_div, n_div;
    logic                             r_zero, n_zero;
    logic [stg_pkg::DUR_BITS-1:0]     r_dur, n_dur;

    logic [QB-1:0]  q_in;
    logic [QB:0]    shifted;
    logic [QB:0]    diff;
    logic           ge;
    logic [31:0]    period32;
    logic           flag;
    logic [TIMER_BITS-1:0] reload;
    logic           accept;

    assign q_in    = i_frequency[stg_pkg::FREQ_BITS-1:stg_pkg::FREQ_SHIFT];
    assign shifted = {r_rem, r_quo[DB-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign ge      = shifted >= {1'b0, r_div};

    // A period that does not fit the timer saturates the reload to zero.
    assign period32 = 32'(r_quo);
    assign flag     = r_zero || ((period32 >> TIMER_BITS) != 32'd0);
    assign reload   = flag ? '0 : ~period32[TIMER_BITS-1:0];

    assign o_ready = (r_state == ST_IDLE) && !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_push = 1'b0;
        o_data = {stg_pkg::CMD_TICK, 1'b0, {TIMER_BITS{1'b0}}, {stg_pkg::DUR_BITS{1'b0}}};
        if (r_state == ST_PUSH) begin
            o_push = !i_full;
            o_data = {stg_pkg::CMD_START, flag, reload, r_dur};
        end else if (accept && i_command == stg_pkg::CMD_TICK) begin
            o_push = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        n_zero  = r_zero;
        n_dur   = r_dur;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_command == stg_pkg::CMD_START) begin
                    n_quo   = DB'(stg_pkg::PERIOD_SCALE) + DB'(q_in) - DB'(1);
                    n_rem   = '0;
                    n_div   = q_in;
                    n_zero  = (q_in == '0);
                    n_dur   = i_duration_ms;
                    n_cnt   = CB'(DB - 1);
                    n_state = (q_in == '0) ? ST_PUSH : ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem = ge ? diff[QB-1:0] : shifted[QB-1:0];
                n_quo = {r_quo[DB-2:0], ge};
                n_cnt = r_cnt - CB'(1);
                if (r_cnt == '0) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!i_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt  <= n_cnt;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_zero <= n_zero;
        r_dur  <= n_dur;
    end

endmodule

`default_nettype wire

[rtl/stg_queue.sv]
// ----------------------------------------------------------------------------
// stg_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_queue #(
    parameter int WIDTH = 34
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/stg_back.sv]
// ----------------------------------------------------------------------------
// stg_back
// Runs queued requests against the tone timer, the pins and the duration
// count, and holds each result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_back #(
    parameter int TIMER_BITS = stg_pkg::TIMER_BITS_DEF,
    parameter int QW         = 2 + TIMER_BITS + stg_pkg::DUR_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire stg_pkg::t_cfg i_cfg,
    input  wire logic [QW-1:0] i_data,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_step_level,
    output logic               o_direction_level,
    output logic               o_playing,
    output logic               o_note_finished,
    output logic               o_bad_frequency
);

    localparam int DW = stg_pkg::DUR_BITS;

    logic                  q_cmd;
    logic                  q_flag;
    logic [TIMER_BITS-1:0] q_reload;
    logic [DW-1:0]         q_dur;

    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [TIMER_BITS-1:0] r_reload, n_reload;
    logic [7:0]            r_toggles, n_toggles;
    logic                  r_step, n_step;
    logic                  r_dir, n_dir;
    logic [DW-1:0]         r_ms, n_ms;
    logic [15:0]           r_tick, n_tick;
    logic                  r_run, n_run;
    logic                  r_flag, n_flag;
    logic                  n_fin;

    logic                  r_valid;
    logic                  r_o_step, r_o_dir, r_o_play, r_o_fin, r_o_flag;

    logic [7:0]            toggles_inc;
    logic [15:0]           tick_inc;
    logic [DW-1:0]         ms_dec;

    assign {q_cmd, q_flag, q_reload, q_dur} = i_data;

    assign o_pop = !i_empty && (!r_valid || i_ready);

    assign toggles_inc = r_toggles + 8'd1;
    assign tick_inc    = r_tick + 16'd1;
    assign ms_dec      = r_ms - DW'(1);

    always_comb begin
        n_timer   = r_timer;
        n_reload  = r_reload;
        n_toggles = r_toggles;
        n_step    = r_step;
        n_dir     = r_dir;
        n_ms      = r_ms;
        n_tick    = r_tick;
        n_run     = r_run;
        n_flag    = r_flag;
        n_fin     = 1'b0;
        if (q_cmd == stg_pkg::CMD_START) begin
            n_reload = q_reload;
            n_timer  = q_reload;
            n_flag   = q_flag;
            n_ms     = q_dur;
            n_tick   = '0;
            n_run    = (q_dur != '0);
        end else if (r_run) begin
            if (&r_timer) begin
                n_timer   = r_reload;
                n_toggles = toggles_inc;
                n_step    = ~r_step;
                if (i_cfg.reverse_enable && toggles_inc == i_cfg.step_limit) begin
                    n_toggles = '0;
                    n_dir     = ~r_dir;
                end
            end else begin
                n_timer = r_timer + TIMER_BITS'(1);
            end
            n_tick = tick_inc;
            // A millisecond ends on an exact match, so a lowered limit waits for the wrap.
            if (tick_inc == i_cfg.ticks_per_ms) begin
                n_tick = '0;
                n_ms   = ms_dec;
                if (ms_dec == '0) begin
                    n_run = 1'b0;
                    n_fin = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer   <= '0;
            r_reload  <= '0;
            r_toggles <= '0;
            r_step    <= 1'b0;
            r_dir     <= 1'b0;
            r_ms      <= '0;
            r_tick    <= '0;
            r_run     <= 1'b0;
            r_flag    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_timer   <= n_timer;
                r_reload  <= n_reload;
                r_toggles <= n_toggles;
                r_step    <= n_step;
                r_dir     <= n_dir;
                r_ms      <= n_ms;
                r_tick    <= n_tick;
                r_run     <= n_run;
                r_flag    <= n_flag;
                r_valid   <= 1'b1;
            end else if (i_ready) begin
                r_valid   <= 1'b0;
            end
        end
        if (o_pop) begin
            r_o_step <= n_step;
            r_o_dir  <= n_dir;
            r_o_play <= n_run;
            r_o_fin  <= n_fin;
            r_o_flag <= n_flag;
        end
    end

    assign o_valid           = r_valid;
    assign o_step_level      = r_o_step;
    assign o_direction_level = r_o_dir;
    assign o_playing         = r_o_play;
    assign o_note_finished   = r_o_fin;
    assign o_bad_frequency   = r_o_flag;

endmodule

`default_nettype wire

[rtl/stg_checker.sv]
// ----------------------------------------------------------------------------
// stg_checker
// Port-level checks of the stepper tone generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_step,
    input wire logic i_dir,
    input wire logic i_playing,
    input wire logic i_finished,
    input wire logic i_bad
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_step) && $stable(i_dir) && $stable(i_playing) &&
            $stable(i_finished) && $stable(i_bad))
        else $error("stalled result changed");

    // The tick that ends a note also stops it.
    a_finish_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_finished |-> !i_playing)
        else $error("note finished but still playing");

    // No result can be ready in the first cycle out of reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !i_out_valid)
        else $error("result offered right after reset");

endmodule

bind stepper_tone_generator_unit stg_checker u_stg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_step      (o_out.step_level),
    .i_dir       (o_out.direction_level),
    .i_playing   (o_out.playing),
    .i_finished  (o_out.note_finished),
    .i_bad       (o_out.bad_frequency)
);

`default_nettype wire
